>>> rtl/hgov_pkg.sv
// ----------------------------------------------------------------------------
// Hotplug governor package
// Shared constants, register indexes and the divider request type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hgov_pkg;

  // Core count and load fields.
  localparam int DefNumCores = 4;
  localparam int LoadFields  = 4;
  localparam int LoadW       = 7;
  localparam int MaskW       = 4;
  localparam int CountW      = 3;
  localparam int TimeW       = 48;
  localparam int IntervalW   = 16;

  // Load sum over at most four cores of at most 100 percent each.
  localparam int SumW        = 9;
  // Interval in microseconds: 65535 * 1000 fits in 26 bits.
  localparam int LimitW      = 26;

  localparam logic [LoadW-1:0]     LoadMax        = 7'd100;
  localparam logic [IntervalW-1:0] MinIntervalMs  = 16'd20;
  localparam logic [9:0]           UsPerMs        = 10'd1000;

  // Reset values of the configuration registers.
  localparam logic [IntervalW-1:0] DefIntervalMs  = 16'd200;
  localparam logic [LoadW-1:0]     DefUpThres     = 7'd75;
  localparam logic [LoadW-1:0]     DefDownThres   = 7'd25;
  localparam logic [CountW-1:0]    DefMaxCores    = 3'd4;
  localparam logic [CountW-1:0]    DefMinCores    = 3'd1;

  // Configuration register indexes.
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgEnable   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgDynamic  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgInterval = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgUpThres  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgDnThres  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgMaxCores = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgMinCores = 3'd6;

  localparam int CfgDataW = IntervalW;

  // Request to the iterative divider.
  typedef struct packed {
    logic              start;
    logic [SumW-1:0]   dividend;
    logic [CountW-1:0] divisor;
  } div_req_t;

endpackage

`default_nettype wire

>>> rtl/hgov_div.sv
// ----------------------------------------------------------------------------
// Hotplug governor divider
// Restoring divider that yields one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hgov_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire hgov_pkg::div_req_t        req_i,
  output logic                           done_o,
  output logic [hgov_pkg::SumW-1:0]      quotient_o
);
  import hgov_pkg::*;

  localparam int StepW = $clog2(SumW + 1);
  localparam logic [StepW-1:0] LastStep = StepW'(SumW - 1);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [StepW-1:0]    step_q, step_d;
  logic [SumW-1:0]     quo_q, quo_d;
  logic [CountW-1:0]   rem_q, rem_d;
  logic [CountW-1:0]   den_q, den_d;
  logic [CountW:0]     shifted;
  logic                fits;

  // Partial remainder with the next dividend bit shifted in.
  assign shifted = {rem_q, quo_q[SumW-1]};
  assign fits    = shifted >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      den_d  = req_i.divisor;
    end else if (busy_q) begin
      quo_d = {quo_q[SumW-2:0], fits};
      rem_d = fits ? CountW'(shifted - {1'b0, den_q}) : shifted[CountW-1:0];
      step_d = step_q + StepW'(1);
      if (step_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

>>> rtl/load_based_core_hotplug_governor_unit.sv
// ----------------------------------------------------------------------------
// Load-based core hotplug governor
// Steps a target core count against load thresholds and requests hotplug.
// ----------------------------------------------------------------------------
// Usage: each request on the input channel is one load notification (time,
// display state, online mask, per-core load). For every request exactly one
// result leaves on the output channel. Both channels use valid and stall.
// The configuration port writes one register per enabled cycle; write it
// only while no request is in flight.
// Sequence: an inactive request goes from StLimit to StEmit; a rate-limited
// one passes StLimit, StCheck and StEmit. An evaluated request also runs the
// accumulate sweep over the used cores (StAcc), StAvg, the bit-serial divider
// (StDiv) when any core is online, and StStep before StEmit.
// A new request is taken in the cycle after the previous one has reached the
// output register, so requests are handled one at a time.
// Reset sets the configuration registers to their defaults, the target to
// the maximum core count and the last sample time to zero. While the
// receiver stalls, the result holds and one further request may be
// processed up to the point where it needs the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module load_based_core_hotplug_governor_unit #(
  parameter int NumCores = hgov_pkg::DefNumCores
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Configuration
  input  wire logic                           cfg_we_i,
  input  wire logic [hgov_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [hgov_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // Input channel
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [hgov_pkg::TimeW-1:0]     time_us_i,
  input  wire logic                           display_on_i,
  input  wire logic [hgov_pkg::MaskW-1:0]     online_mask_i,
  input  wire logic [hgov_pkg::LoadW-1:0]     load_core0_i,
  input  wire logic [hgov_pkg::LoadW-1:0]     load_core1_i,
  input  wire logic [hgov_pkg::LoadW-1:0]     load_core2_i,
  input  wire logic [hgov_pkg::LoadW-1:0]     load_core3_i,
  // Output channel
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [hgov_pkg::CountW-1:0]         target_cores_o,
  output logic                                evaluated_o,
  output logic                                apply_o,
  output logic [hgov_pkg::MaskW-1:0]          bring_up_mask_o,
  output logic [hgov_pkg::MaskW-1:0]          take_down_mask_o
);
  import hgov_pkg::*;

  localparam int UsedCores = (NumCores < LoadFields) ? NumCores : LoadFields;
  localparam int IdxW      = (UsedCores > 1) ? $clog2(UsedCores) : 1;
  localparam logic [IdxW-1:0]   LastIdx    = IdxW'(UsedCores - 1);
  localparam logic [CountW:0]   NumCoresW  = (CountW + 1)'(NumCores);
  localparam logic [CountW-1:0] CapCores   = CountW'(NumCores);
  localparam logic [CountW-1:0] UsedCoresW = CountW'(UsedCores);
  localparam logic [CountW-1:0] RstTarget  =
    (DefNumCores > NumCores) ? CountW'(NumCores) : DefMaxCores;
  localparam logic [MaskW-1:0]  UsedMask   = MaskW'((1 << UsedCores) - 1);

  // Sequencer states.
  localparam int StW = 3;
  localparam logic [StW-1:0] StIdle  = 3'd0;
  localparam logic [StW-1:0] StLimit = 3'd1;
  localparam logic [StW-1:0] StCheck = 3'd2;
  localparam logic [StW-1:0] StAcc   = 3'd3;
  localparam logic [StW-1:0] StAvg   = 3'd4;
  localparam logic [StW-1:0] StDiv   = 3'd5;
  localparam logic [StW-1:0] StStep  = 3'd6;
  localparam logic [StW-1:0] StEmit  = 3'd7;

  // Configuration registers.
  logic                 enable_q;
  logic                 dynamic_q;
  logic [IntervalW-1:0] interval_q;
  logic [LoadW-1:0]     up_thres_q;
  logic [LoadW-1:0]     dn_thres_q;
  logic [CountW-1:0]    max_cores_q;
  logic [CountW-1:0]    min_cores_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b0;
      dynamic_q   <= 1'b0;
      interval_q  <= DefIntervalMs;
      up_thres_q  <= DefUpThres;
      dn_thres_q  <= DefDownThres;
      max_cores_q <= DefMaxCores;
      min_cores_q <= DefMinCores;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgEnable:   enable_q    <= cfg_wdata_i[0];
        CfgDynamic:  dynamic_q   <= cfg_wdata_i[0];
        CfgInterval: interval_q  <= cfg_wdata_i;
        CfgUpThres:  up_thres_q  <= cfg_wdata_i[LoadW-1:0];
        CfgDnThres:  dn_thres_q  <= cfg_wdata_i[LoadW-1:0];
        CfgMaxCores: max_cores_q <= cfg_wdata_i[CountW-1:0];
        CfgMinCores: min_cores_q <= cfg_wdata_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Bounds limited to the number of cores present.
  logic [CountW-1:0] maxc, minc;
  assign maxc = ({1'b0, max_cores_q} > NumCoresW) ? CapCores : max_cores_q;
  assign minc = ({1'b0, min_cores_q} > NumCoresW) ? CapCores : min_cores_q;

  // Control and result state.
  logic [StW-1:0]    state_q, state_d;
  logic [CountW-1:0] target_q, target_d;
  logic [TimeW-1:0]  last_time_q, last_time_d;
  logic              eval_q, eval_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;

  // Captured request and working values.
  logic                        active_q;
  logic [TimeW-1:0]            time_q;
  logic [MaskW-1:0]            online_q;
  logic [LoadFields-1:0][LoadW-1:0] loads_q;
  logic [TimeW-1:0]            diff_q, diff_d;
  logic [LimitW-1:0]           limit_q, limit_d;
  logic [SumW-1:0]             sum_q, sum_d;
  logic [SumW-1:0]             avg_q, avg_d;

  logic [CountW-1:0] out_target_q;
  logic              out_eval_q, out_apply_q;
  logic [MaskW-1:0]  out_up_q, out_down_q;

  logic              accept;
  logic              out_free;
  logic [IntervalW-1:0] interval_eff;
  logic [CountW:0]   target_inc;
  logic [CountW-1:0] clip_t;
  logic [MaskW:0]    desired_w;
  logic [MaskW-1:0]  desired;
  logic              apply_w;
  div_req_t          div_req;
  logic              div_done;
  logic [SumW-1:0]   div_quo;

  assign accept       = in_valid_i && (state_q == StIdle);
  assign out_free     = !out_valid_q || !out_stall_i;
  assign interval_eff = (interval_q < MinIntervalMs) ? MinIntervalMs : interval_q;
  assign target_inc   = {1'b0, target_q} + (CountW + 1)'(1);

  // Target mask for cores 0..target-1, limited to the cores with a load field.
  assign clip_t    = (target_q > UsedCoresW) ? UsedCoresW : target_q;
  assign desired_w = ((MaskW + 1)'(1) << clip_t) - (MaskW + 1)'(1);
  assign desired   = desired_w[MaskW-1:0];
  assign apply_w   = eval_q && (cnt_q != target_q);

  hgov_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    state_d     = state_q;
    target_d    = target_q;
    last_time_d = last_time_q;
    eval_d      = eval_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    diff_d      = diff_q;
    limit_d     = limit_q;
    sum_d       = sum_q;
    avg_d       = avg_q;
    out_valid_d = out_valid_q && out_stall_i;
    div_req     = '{start: 1'b0, dividend: sum_q, divisor: cnt_q};

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StLimit;
        end
      end
      StLimit: begin
        eval_d = 1'b0;
        if (!active_q) begin
          target_d    = maxc;
          last_time_d = time_q;
          state_d     = StEmit;
        end else begin
          diff_d  = time_q - last_time_q;
          limit_d = LimitW'(interval_eff) * LimitW'(UsPerMs);
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (diff_q < {{(TimeW - LimitW){1'b0}}, limit_q}) begin
          state_d = StEmit;
        end else begin
          last_time_d = time_q;
          idx_d       = '0;
          cnt_d       = '0;
          sum_d       = '0;
          state_d     = StAcc;
        end
      end
      StAcc: begin
        if (online_q[idx_q]) begin
          sum_d = sum_q + SumW'(loads_q[idx_q]);
          cnt_d = cnt_q + CountW'(1);
        end
        idx_d = idx_q + IdxW'(1);
        if (idx_q == LastIdx) begin
          state_d = StAvg;
        end
      end
      StAvg: begin
        // With no core online the average is zero.
        if (cnt_q == '0) begin
          avg_d   = '0;
          state_d = StStep;
        end else begin
          div_req.start = 1'b1;
          state_d       = StDiv;
        end
      end
      StDiv: begin
        if (div_done) begin
          avg_d   = div_quo;
          state_d = StStep;
        end
      end
      StStep: begin
        eval_d = 1'b1;
        if (avg_q >= SumW'(up_thres_q)) begin
          target_d = (target_inc > {1'b0, maxc}) ? maxc : target_inc[CountW-1:0];
        end else if (avg_q <= SumW'(dn_thres_q)) begin
          if ((target_q == '0) || ((target_q - CountW'(1)) < minc)) begin
            target_d = minc;
          end else begin
            target_d = target_q - CountW'(1);
          end
        end
        state_d = StEmit;
      end
      StEmit: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      target_q    <= RstTarget;
      last_time_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      target_q    <= target_d;
      last_time_q <= last_time_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    eval_q  <= eval_d;
    idx_q   <= idx_d;
    cnt_q   <= cnt_d;
    diff_q  <= diff_d;
    limit_q <= limit_d;
    sum_q   <= sum_d;
    avg_q   <= avg_d;
    if (accept) begin
      active_q   <= enable_q && dynamic_q && display_on_i;
      time_q     <= time_us_i;
      online_q   <= online_mask_i & UsedMask;
      loads_q[0] <= (load_core0_i > LoadMax) ? LoadMax : load_core0_i;
      loads_q[1] <= (load_core1_i > LoadMax) ? LoadMax : load_core1_i;
      loads_q[2] <= (load_core2_i > LoadMax) ? LoadMax : load_core2_i;
      loads_q[3] <= (load_core3_i > LoadMax) ? LoadMax : load_core3_i;
    end
    if ((state_q == StEmit) && out_free) begin
      out_target_q <= target_q;
      out_eval_q   <= eval_q;
      out_apply_q  <= apply_w;
      out_up_q     <= apply_w ? (desired & ~online_q) : '0;
      out_down_q   <= apply_w ? (online_q & ~desired) : '0;
    end
  end

  assign in_stall_o       = (state_q != StIdle);
  assign out_valid_o      = out_valid_q;
  assign target_cores_o   = out_target_q;
  assign evaluated_o      = out_eval_q;
  assign apply_o          = out_apply_q;
  assign bring_up_mask_o  = out_up_q;
  assign take_down_mask_o = out_down_q;

endmodule

`default_nettype wire
